/* rtl/core/lcalc_pkg.sv */
// Shared types, constants and the ratio band lookup of the lux calculation.
// Used by every module under rtl/core; depends on nothing else.
package lcalc_pkg;

  localparam int unsigned LCALC_DIV_STEPS = 10;
  localparam int unsigned LCALC_LATENCY   = LCALC_DIV_STEPS + 4;

  localparam int unsigned SCALE_W = 19;
  localparam int unsigned C0_W    = 22;
  localparam int unsigned C1_W    = 21;
  localparam int unsigned REM_W   = 31;
  localparam int unsigned QUO_W   = LCALC_DIV_STEPS;
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned COEF_W  = 10;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned LUX_W   = 18;
  localparam int unsigned BB_W    = 16;
  localparam int unsigned CFG_W   = 2;

  localparam int unsigned CHAN_SHIFT = 10;
  localparam int unsigned LUX_SHIFT  = 14;

  localparam logic [SCALE_W-1:0] SCALE_T0   = 19'h07517;
  localparam logic [SCALE_W-1:0] SCALE_T1   = 19'h00FE7;
  localparam logic [SCALE_W-1:0] SCALE_UNIT = 19'h00400;
  localparam logic [BB_W-1:0]    BB_LIMIT   = 16'd4900;
  localparam logic [LUX_W-1:0]   LUX_OVF    = 18'h3FFFF;
  localparam logic [PROD_W:0]    LUX_ROUND  = 33'h000002000;

  localparam logic [COEF_W-1:0] RATIO_EDGE [7] = '{
    10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A
  };
  localparam logic [COEF_W-1:0] OFFSET_B [8] = '{
    10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000
  };
  localparam logic [COEF_W-1:0] SLOPE_M [8] = '{
    10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000
  };

  typedef enum logic [0:0] {
    REG_GAIN_HIGH = 1'b0,
    REG_INT_TIME  = 1'b1
  } lcalc_reg_e;

  typedef enum logic [1:0] {
    TINT_SHORT  = 2'd0,
    TINT_MEDIUM = 2'd1,
    TINT_LONG   = 2'd2
  } lcalc_tint_e;

  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_OVF  = 2'd2
  } lcalc_kind_e;

  typedef struct packed {
    lcalc_kind_e        kind;
    logic [C0_W-1:0]    c0;
    logic [C1_W-1:0]    c1;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   dvs;
    logic [QUO_W-1:0]   quo;
  } lcalc_div_t;

  // First band whose edge is not below the ratio; past the last edge use band 7.
  function automatic logic [SEL_W-1:0] lcalc_select(input logic [COEF_W-1:0] ratio);
    logic [SEL_W-1:0] sel;
    sel = SEL_W'(7);
    for (int i = 6; i >= 0; i--) begin
      if (ratio <= RATIO_EDGE[i]) begin
        sel = SEL_W'(i);
      end
    end
    return sel;
  endfunction

endpackage

/* rtl/core/lcalc_scale.sv */
// Front stage: range checks and channel scaling by integration time and gain.
// Depends on lcalc_pkg; feeds the first divider cell.
module lcalc_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_i,
  input  logic [lcalc_pkg::BB_W-1:0]      broadband_count_i,
  input  logic [lcalc_pkg::BB_W-1:0]      infrared_count_i,
  input  logic                            gain_high_i,
  input  logic [lcalc_pkg::CFG_W-1:0]     integration_time_i,
  output logic                            valid_o,
  output lcalc_pkg::lcalc_div_t           data_o
);

  logic [lcalc_pkg::SCALE_W-1:0] base;
  logic [lcalc_pkg::SCALE_W-1:0] scale;
  logic [lcalc_pkg::PROD_W-1:0]  prod0;
  logic [lcalc_pkg::PROD_W-1:0]  prod1;
  lcalc_pkg::lcalc_kind_e        kind;
  logic                          valid_q;
  lcalc_pkg::lcalc_div_t         data_d;
  lcalc_pkg::lcalc_div_t         data_q;

  always_comb begin
    case (integration_time_i)
      lcalc_pkg::TINT_SHORT:  base = lcalc_pkg::SCALE_T0;
      lcalc_pkg::TINT_MEDIUM: base = lcalc_pkg::SCALE_T1;
      default:                base = lcalc_pkg::SCALE_UNIT;
    endcase
    scale = gain_high_i ? base : (base << 4);
  end

  always_comb begin
    if (infrared_count_i == '0) begin
      kind = lcalc_pkg::KIND_ZERO;
    end else if (({1'b0, infrared_count_i} << 1) <= {1'b0, broadband_count_i} &&
                 broadband_count_i <= lcalc_pkg::BB_LIMIT) begin
      kind = lcalc_pkg::KIND_CALC;
    end else begin
      kind = lcalc_pkg::KIND_OVF;
    end
  end

  // In range the broadband count fits 13 bits and infrared 12 bits.
  assign prod0 = lcalc_pkg::PROD_W'(broadband_count_i[12:0]) * lcalc_pkg::PROD_W'(scale);
  assign prod1 = lcalc_pkg::PROD_W'(infrared_count_i[11:0]) * lcalc_pkg::PROD_W'(scale);

  always_comb begin
    data_d.kind = kind;
    data_d.c0   = prod0[lcalc_pkg::CHAN_SHIFT +: lcalc_pkg::C0_W];
    data_d.c1   = prod1[lcalc_pkg::CHAN_SHIFT +: lcalc_pkg::C1_W];
    data_d.rem  = {data_d.c1, 10'b0};
    data_d.dvs  = {data_d.c0, 9'b0};
    data_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/lcalc_div_cell.sv */
// One restoring division step of the ratio chain: compare, subtract, shift.
// Depends on lcalc_pkg; instantiated in a row by the top level.
module lcalc_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  lcalc_pkg::lcalc_div_t data_i,
  output logic                  valid_o,
  output lcalc_pkg::lcalc_div_t data_o
);

  logic                  ge;
  logic                  valid_q;
  lcalc_pkg::lcalc_div_t data_d;
  lcalc_pkg::lcalc_div_t data_q;

  assign ge = (data_i.rem >= data_i.dvs);

  always_comb begin
    data_d      = data_i;
    data_d.rem  = ge ? (data_i.rem - data_i.dvs) : data_i.rem;
    data_d.quo  = {data_i.quo[lcalc_pkg::QUO_W-2:0], ge};
    // halve the divisor for the next quotient bit
    data_d.dvs  = data_i.dvs >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/lcalc_lux_out.sv */
// Tail stages: band select from the rounded ratio, coefficient products,
// clamp, rounding and output register. Depends on lcalc_pkg.
module lcalc_lux_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  lcalc_pkg::lcalc_div_t             data_i,
  output logic                              valid_o,
  output logic signed [lcalc_pkg::LUX_W-1:0] lux_o
);

  // band select stage
  logic [lcalc_pkg::QUO_W:0]    ratio_sum;
  logic                         sel_valid_q;
  lcalc_pkg::lcalc_kind_e       sel_kind_q;
  logic [lcalc_pkg::C0_W-1:0]   sel_c0_q;
  logic [lcalc_pkg::C1_W-1:0]   sel_c1_q;
  logic [lcalc_pkg::SEL_W-1:0]  sel_q;

  // product stage
  logic                         mul_valid_q;
  lcalc_pkg::lcalc_kind_e       mul_kind_q;
  logic [lcalc_pkg::PROD_W-1:0] pos_q;
  logic [lcalc_pkg::PROD_W-1:0] neg_q;

  // output stage
  logic [lcalc_pkg::PROD_W-1:0] diff;
  logic [lcalc_pkg::PROD_W:0]   rounded;
  logic [lcalc_pkg::LUX_W-1:0]  lux_d;
  logic [lcalc_pkg::LUX_W-1:0]  lux_q;
  logic                         out_valid_q;

  assign ratio_sum = {1'b0, data_i.quo} + (lcalc_pkg::QUO_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_valid_q <= valid_i;
      mul_valid_q <= sel_valid_q;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sel_kind_q <= data_i.kind;
      sel_c0_q   <= data_i.c0;
      sel_c1_q   <= data_i.c1;
      sel_q      <= lcalc_pkg::lcalc_select(ratio_sum[lcalc_pkg::QUO_W:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_valid_q) begin
      mul_kind_q <= sel_kind_q;
      pos_q <= lcalc_pkg::PROD_W'(sel_c0_q) * lcalc_pkg::PROD_W'(lcalc_pkg::OFFSET_B[sel_q]);
      neg_q <= lcalc_pkg::PROD_W'(sel_c1_q) * lcalc_pkg::PROD_W'(lcalc_pkg::SLOPE_M[sel_q]);
    end
  end

  always_comb begin
    // clamp a negative difference at zero before rounding
    diff    = (pos_q > neg_q) ? (pos_q - neg_q) : '0;
    rounded = {1'b0, diff} + lcalc_pkg::LUX_ROUND;
    case (mul_kind_q)
      lcalc_pkg::KIND_CALC: lux_d = {1'b0, rounded[lcalc_pkg::LUX_SHIFT +: lcalc_pkg::LUX_W-1]};
      lcalc_pkg::KIND_ZERO: lux_d = '0;
      default:              lux_d = lcalc_pkg::LUX_OVF;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q) begin
      lux_q <= lux_d;
    end
  end

  assign valid_o = out_valid_q;
  assign lux_o   = lux_q;

endmodule

/* rtl/core/dual_channel_lux_calculation.sv */
// Top level of the two-channel lux calculation: config registers, scaling
// stage, a row of division cells and the output stages. Depends on lcalc_pkg.
//
//   channel   signals                                       direction
//   request   start_i, busy_o, broadband_count_i,
//             infrared_count_i                              in (busy_o out)
//   result    lux_valid_o, lux_o                            out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i              in
//
// One request is taken per cycle while busy_o is low; busy_o is high only in the cycle after reset.
// Each result passes one scaling stage, ten
// division cells (one quotient bit each) and three output stages.
// Reset clears all valid flags and sets gain_high = 0, integration_time = 1.
// The result strobe lasts one cycle; nothing downstream can stall the pipe.
module dual_channel_lux_calculation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [lcalc_pkg::BB_W-1:0]         broadband_count_i,
  input  logic [lcalc_pkg::BB_W-1:0]         infrared_count_i,
  output logic                               lux_valid_o,
  output logic signed [lcalc_pkg::LUX_W-1:0] lux_o,
  input  logic                               cfg_we_i,
  input  lcalc_pkg::lcalc_reg_e              cfg_idx_i,
  input  logic [lcalc_pkg::CFG_W-1:0]        cfg_wdata_i
);

  logic                              busy_q;
  logic                              gain_high_q;
  logic [lcalc_pkg::CFG_W-1:0]       int_time_q;
  logic                              req;
  logic [lcalc_pkg::LCALC_DIV_STEPS:0] chain_valid;
  lcalc_pkg::lcalc_div_t             chain_data [lcalc_pkg::LCALC_DIV_STEPS+1];

  assign req    = start_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      gain_high_q <= 1'b0;
      int_time_q  <= lcalc_pkg::TINT_MEDIUM;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcalc_pkg::REG_GAIN_HIGH: gain_high_q <= cfg_wdata_i[0];
          lcalc_pkg::REG_INT_TIME:  int_time_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  lcalc_scale u_scale (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_i              (req),
    .broadband_count_i  (broadband_count_i),
    .infrared_count_i   (infrared_count_i),
    .gain_high_i        (gain_high_q),
    .integration_time_i (int_time_q),
    .valid_o            (chain_valid[0]),
    .data_o             (chain_data[0])
  );

  for (genvar g = 0; g < lcalc_pkg::LCALC_DIV_STEPS; g++) begin : g_div
    lcalc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  lcalc_lux_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[lcalc_pkg::LCALC_DIV_STEPS]),
    .data_i  (chain_data[lcalc_pkg::LCALC_DIV_STEPS]),
    .valid_o (lux_valid_o),
    .lux_o   (lux_o)
  );

endmodule

/* rtl/core/lcalc_checker.sv */
// Port-level checks on the lux calculation: latency, special results.
// Depends on lcalc_pkg; bound to dual_channel_lux_calculation below.
module lcalc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic [lcalc_pkg::BB_W-1:0]         broadband_count_i,
  input logic [lcalc_pkg::BB_W-1:0]         infrared_count_i,
  input logic                               lux_valid_o,
  input logic signed [lcalc_pkg::LUX_W-1:0] lux_o
);

  logic req;
  logic out_of_range;

  assign req          = start_i && !busy_o;
  assign out_of_range = (infrared_count_i != '0) &&
                        ((broadband_count_i > lcalc_pkg::BB_LIMIT) ||
                         (({1'b0, infrared_count_i} << 1) > {1'b0, broadband_count_i}));

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##(lcalc_pkg::LCALC_LATENCY) lux_valid_o)
    else $error("request without a result at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req |-> ##(lcalc_pkg::LCALC_LATENCY) !lux_valid_o)
    else $error("result strobe without a matching request");

  a_zero_ir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && infrared_count_i == '0) |-> ##(lcalc_pkg::LCALC_LATENCY) (lux_o == '0))
    else $error("zero infrared count did not give zero lux");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && out_of_range) |-> ##(lcalc_pkg::LCALC_LATENCY) (lux_o == lcalc_pkg::LUX_OVF))
    else $error("out of range counts did not give the overflow flag");

endmodule

bind dual_channel_lux_calculation lcalc_checker u_lcalc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .broadband_count_i (broadband_count_i),
  .infrared_count_i  (infrared_count_i),
  .lux_valid_o       (lux_valid_o),
  .lux_o             (lux_o)
);
